// ===== src/bblc_pkg.sv =====
// Shared types and constants for the byte-budget LRU cache.
package bblc_pkg;

  localparam int unsigned Entries = 64;
  localparam int unsigned IdxW = $clog2(Entries);
  localparam int unsigned CntW = $clog2(Entries + 1);
  localparam int unsigned StampW = 64;

  localparam logic [2:0] FuncGet    = 3'd0;
  localparam logic [2:0] FuncPut    = 3'd1;
  localparam logic [2:0] FuncRemove = 3'd2;
  localparam logic [2:0] FuncClear  = 3'd3;
  localparam logic [2:0] FuncTrim   = 3'd4;

  localparam logic [39:0] MaxBytesReset = 40'd268435456;
  localparam logic [47:0] Sat48 = {48{1'b1}};

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] key;
    logic [31:0] handle;
    logic [31:0] entry_bytes;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] handle_out;
    logic [6:0]  evicted;
    logic [6:0]  entry_count;
    logic [39:0] current_bytes;
    logic [47:0] hit_total;
    logic [47:0] miss_total;
    logic [47:0] evict_total;
  } rsp_t;

  // Command from the sequencer to the slot store for one sweep step.
  typedef struct packed {
    logic            sweep;     // visit one slot at scan_idx
    logic [IdxW-1:0] scan_idx;
  } scan_t;

endpackage

// ===== src/bblc_store.sv =====
// Slot store: key, handle, size and recency-stamp memories, read one slot per cycle.
module bblc_store (
  input  logic                        clk_i,
  input  logic [bblc_pkg::IdxW-1:0]   rd_idx_i,
  output logic [31:0]                 rd_key_o,
  output logic [31:0]                 rd_handle_o,
  output logic [31:0]                 rd_size_o,
  output logic [bblc_pkg::StampW-1:0] rd_stamp_o,
  input  logic                        wr_en_i,
  input  logic                        stamp_we_i,
  input  logic [bblc_pkg::IdxW-1:0]   wr_idx_i,
  input  logic [31:0]                 wr_key_i,
  input  logic [31:0]                 wr_handle_i,
  input  logic [31:0]                 wr_size_i,
  input  logic [bblc_pkg::StampW-1:0] wr_stamp_i
);
  import bblc_pkg::*;

  logic [31:0] key_mem [Entries];
  logic [31:0] hnd_mem [Entries];
  logic [31:0] size_mem [Entries];
  logic [StampW-1:0] stamp_mem [Entries];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_idx_i]  <= wr_key_i;
      hnd_mem[wr_idx_i]  <= wr_handle_i;
      size_mem[wr_idx_i] <= wr_size_i;
    end
    if (stamp_we_i) stamp_mem[wr_idx_i] <= wr_stamp_i;
    rd_key_o    <= key_mem[rd_idx_i];
    rd_handle_o <= hnd_mem[rd_idx_i];
    rd_size_o   <= size_mem[rd_idx_i];
    rd_stamp_o  <= stamp_mem[rd_idx_i];
  end

endmodule

// ===== src/byte_budget_lru_cache.sv =====
// Byte-budget LRU cache: a 64-slot key-tagged cache whose summed entry sizes are held
// to a programmable byte budget by eviction, driven by one sequencer over slot-serial
// sweeps. A get, put or remove sweeps the slots one per cycle through a single
// key-compare and recency-compare unit, reading all 64 slots from the registered slot
// store, and every eviction adds a further sweep; trim sweeps only to evict, and clear
// and unknown operations do not sweep. The result waits in an output register and
// nothing new is accepted until it is taken. Recency is a per-slot stamp from a running
// counter: the valid slot with the smallest stamp is the least recent.
module byte_budget_lru_cache (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bblc_pkg::req_t    in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bblc_pkg::rsp_t    out_data_o,
  input  logic              cfg_we_i,
  input  logic [39:0]       cfg_wdata_i
);
  import bblc_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;  // find key; also tracks the LRU slot
  localparam logic [2:0] StDec   = 3'd2;  // decide next action after a sweep
  localparam logic [2:0] StEvict = 3'd3;  // let the totals settle after a drop
  localparam logic [2:0] StDone  = 3'd4;

  logic [2:0] state_q, state_d;
  req_t req_q;
  rsp_t rsp_q;
  logic out_valid_q;

  logic [39:0] max_bytes_q;
  logic [39:0] bytes_q;
  logic [47:0] hit_q, miss_q, evict_q;
  logic [CntW-1:0] count_q;
  logic [6:0] ev_q;
  logic [StampW-1:0] stamp_q;     // next recency stamp; larger is more recent

  logic [Entries-1:0] valid_q;

  // Sweep pointers: issue address and the address whose data is arriving.
  logic [CntW-1:0] iss_q;
  logic pend_q;                   // delayed issue valid
  logic [IdxW-1:0] ad1_q;

  logic hit_q_f;
  logic [IdxW-1:0] hit_idx_q;
  logic [31:0] hit_hnd_q;
  logic [31:0] hit_size_q;
  logic lru_ok_q;
  logic [IdxW-1:0] lru_idx_q;
  logic [31:0] lru_size_q;
  logic [StampW-1:0] lru_stamp_q;
  logic evict_pass_q;

  logic [IdxW-1:0] rd_idx;
  logic [31:0] rd_key, rd_hnd, rd_size;
  logic [StampW-1:0] rd_stamp;
  logic wr_en;
  logic [IdxW-1:0] free_idx;
  logic free_ok;
  logic do_get, do_ins, stamp_we;
  logic [IdxW-1:0] wr_idx;

  bblc_store u_store (
    .clk_i,
    .rd_idx_i(rd_idx), .rd_key_o(rd_key), .rd_handle_o(rd_hnd), .rd_size_o(rd_size),
    .rd_stamp_o(rd_stamp),
    .wr_en_i(do_ins), .stamp_we_i(stamp_we), .wr_idx_i(wr_idx), .wr_key_i(req_q.key),
    .wr_handle_i(req_q.handle), .wr_size_i(req_q.entry_bytes), .wr_stamp_i(stamp_q)
  );

  scan_t scan;
  assign scan.sweep = (state_q == StScan) && (iss_q < CntW'(Entries));
  assign scan.scan_idx = iss_q[IdxW-1:0];
  assign rd_idx = scan.scan_idx;

  // Lowest free slot: a priority pick over the valid bits.
  always_comb begin
    free_idx = '0;
    free_ok = 1'b0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IdxW'(i);
        free_ok = 1'b1;
      end
    end
  end

  logic [40:0] need;
  assign need = {1'b0, bytes_q} + 41'(req_q.entry_bytes);
  logic over_put, over_trim, full;
  assign over_put  = need > {1'b0, max_bytes_q};
  assign over_trim = bytes_q > max_bytes_q;
  assign full      = count_q >= CntW'(Entries);

  logic is_get, is_put, is_rem, evict_op;
  assign is_get = req_q.func == FuncGet;
  assign is_put = req_q.func == FuncPut;
  assign is_rem = req_q.func == FuncRemove;
  assign evict_op = (is_put && !hit_q_f) || req_q.func == FuncTrim;

  logic want_evict;
  always_comb begin
    want_evict = 1'b0;
    if (count_q != '0) begin
      if (is_put) want_evict = over_put || full;
      else        want_evict = over_trim;
    end
  end

  assign wr_en = (state_q == StDec) && is_put && !hit_q_f && !want_evict;
  assign do_get = (state_q == StDec) && !evict_pass_q && is_get && hit_q_f;
  assign do_ins = !evict_pass_q && wr_en && free_ok;
  assign stamp_we = do_get || do_ins;
  assign wr_idx = do_get ? hit_idx_q : free_idx;

  function automatic logic [47:0] sat_inc(input logic [47:0] v);
    return (v == Sat48) ? v : v + 48'd1;
  endfunction

  assign in_ready_o = (state_q == StIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o = rsp_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i && in_ready_o) begin
        if (in_data_i.func == FuncClear || in_data_i.func > FuncTrim) state_d = StDone;
        else if (in_data_i.func == FuncTrim) state_d = StDec;
        else state_d = StScan;
      end
      StScan: if (!pend_q && iss_q >= CntW'(Entries)) state_d = StDec;
      StDec: begin
        if (evict_pass_q && lru_ok_q) state_d = StEvict;
        else if (want_evict && evict_op) state_d = StScan;
        else state_d = StDone;
      end
      StEvict: state_d = StDec;
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_q <= 1'b0;
      max_bytes_q <= MaxBytesReset;
      bytes_q <= '0;
      hit_q <= '0;
      miss_q <= '0;
      evict_q <= '0;
      count_q <= '0;
      valid_q <= '0;
      iss_q <= '0;
      pend_q <= 1'b0;
      ev_q <= '0;
      stamp_q <= '0;
      hit_q_f <= 1'b0;
      lru_ok_q <= 1'b0;
      evict_pass_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) max_bytes_q <= cfg_wdata_i;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      pend_q <= scan.sweep;
      if (scan.sweep) iss_q <= iss_q + CntW'(1);

      unique case (state_q)
        StIdle: if (in_valid_i && in_ready_o) begin
          ev_q <= '0;
          hit_q_f <= 1'b0;
          iss_q <= '0;
          evict_pass_q <= 1'b0;
          lru_ok_q <= 1'b0;
        end
        StScan: if (pend_q && valid_q[ad1_q]) begin
          if (!evict_pass_q && rd_key == req_q.key) hit_q_f <= 1'b1;
          lru_ok_q <= 1'b1;
        end
        StDec: begin
          iss_q <= '0;
          if (evict_pass_q && lru_ok_q) begin
            // Drop the least recent slot found by the last sweep.
            valid_q[lru_idx_q] <= 1'b0;
            bytes_q <= bytes_q - 40'(lru_size_q);
            count_q <= count_q - CntW'(1);
            evict_q <= sat_inc(evict_q);
            if (ev_q != 7'd127) ev_q <= ev_q + 7'd1;
            evict_pass_q <= 1'b0;
            lru_ok_q <= 1'b0;
          end else if (want_evict && evict_op) begin
            evict_pass_q <= 1'b1;
            lru_ok_q <= 1'b0;
          end else if (!evict_pass_q) begin
            if (is_get) begin
              if (hit_q_f) begin
                hit_q <= sat_inc(hit_q);
                stamp_q <= stamp_q + StampW'(1);
              end else miss_q <= sat_inc(miss_q);
            end else if (is_rem && hit_q_f) begin
              valid_q[hit_idx_q] <= 1'b0;
              bytes_q <= bytes_q - 40'(hit_size_q);
              count_q <= count_q - CntW'(1);
            end else if (do_ins) begin
              valid_q[free_idx] <= 1'b1;
              bytes_q <= bytes_q + 40'(req_q.entry_bytes);
              count_q <= count_q + CntW'(1);
              stamp_q <= stamp_q + StampW'(1);
            end
          end
        end
        StEvict: ;
        StDone: begin
          if (req_q.func == FuncClear) begin
            valid_q <= '0;
            bytes_q <= '0;
            count_q <= '0;
          end
          out_valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    ad1_q <= rd_idx;
    if (state_q == StIdle && in_valid_i && in_ready_o) req_q <= in_data_i;
    if (state_q == StScan && pend_q && valid_q[ad1_q]) begin
      if (!evict_pass_q && rd_key == req_q.key) begin
        hit_idx_q <= ad1_q;
        hit_hnd_q <= rd_hnd;
        hit_size_q <= rd_size;
      end
      if (!lru_ok_q || rd_stamp < lru_stamp_q) begin
        lru_idx_q <= ad1_q;
        lru_size_q <= rd_size;
        lru_stamp_q <= rd_stamp;
      end
    end
    if (state_q == StDone) begin
      rsp_q.found <= hit_q_f && (is_get || is_put || is_rem);
      rsp_q.handle_out <= (is_get && hit_q_f) ? hit_hnd_q : 32'd0;
      rsp_q.evicted <= ev_q;
      rsp_q.entry_count <= (req_q.func == FuncClear) ? 7'd0 : 7'(count_q);
      rsp_q.current_bytes <= (req_q.func == FuncClear) ? 40'd0 : bytes_q;
      rsp_q.hit_total <= hit_q;
      rsp_q.miss_total <= miss_q;
      rsp_q.evict_total <= evict_q;
    end
  end

endmodule

// ===== src/bblc_checker.sv =====
// Port-level checker for the byte-budget LRU cache, bound to the top level.
module bblc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input bblc_pkg::rsp_t out_data_o
);
  import bblc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("accepting while a result waits");

  a_accept_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after acceptance");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.entry_count <= 7'(Entries) && out_data_o.evicted <= 7'(Entries))
    else $error("count out of range");

endmodule

bind byte_budget_lru_cache bblc_checker u_bblc_checker (.*);
